>>> src/deadline_timer_queue_defines.svh
// Assertion macros for the deadline timer queue
`ifndef DEADLINE_TIMER_QUEUE_DEFINES_SVH
`define DEADLINE_TIMER_QUEUE_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define DTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous active-low reset
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dtq_pkg.sv
// Package: types, constants and helpers shared by the deadline timer queue
`default_nettype none
package dtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;
  typedef logic [2:0]    state_t;

  localparam cnt_t CNT_FULL = CW'(QUEUE_DEPTH);

  localparam logic [1:0] MODE_SCHED = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_TICK  = 2'd3;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_REMAIN = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  localparam state_t ST_IDLE = 3'd0;
  localparam state_t ST_INS  = 3'd1;
  localparam state_t ST_PUT  = 3'd2;
  localparam state_t ST_QRY  = 3'd3;
  localparam state_t ST_TICK = 3'd4;
  localparam state_t ST_RESP = 3'd5;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] ticket;
  } entry_t;

  typedef struct packed {
    logic       en;
    ptr_t       addr;
    entry_t     data;
  } mem_wr_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] ticket_out;
    logic [31:0] remaining;
    logic        queue_full;
    logic        last;
  } res_t;

  typedef struct packed {
    logic vld;
    res_t res;
  } out_req_t;

  typedef struct packed {
    state_t state;
    cnt_t   count;
  } status_t;

  // physical slot of logical position k behind head, wrapping at the depth
  function automatic ptr_t slot(input ptr_t head, input cnt_t k);
    logic [CW:0] s;
    s = (CW+1)'(head) + {1'b0, k};
    if (s >= (CW+1)'(QUEUE_DEPTH)) begin
      s = s - (CW+1)'(QUEUE_DEPTH);
    end
    return s[PW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/deadline_timer_queue.sv
// Top level of the deadline timer queue
//
//   channel | direction | handshake         | payload
//   in_     | request   | in_valid/in_stall | mode, duration, query_ticket, tick_time
//   out_    | result    | out_valid/out_stall | kind, ticket_out, remaining, queue_full, last
//
// One request at a time; entries live in a circular buffer in one memory.
// Schedule: a full queue is acked with queue_full set; else each entry whose
// deadline is at or after the new one is shifted back (up to QUEUE_DEPTH - 1).
// Query: an empty queue is answered without a scan, else entries are scanned
// from the head to the match or the end. Clear empties the queue; tick fires each
// timer whose deadline is before the tick time. Memory reads (one per cycle) set
// the per-entry step; an output stall holds it. Reset empties the queue, no sweep.
`default_nettype none
`include "deadline_timer_queue_defines.svh"
module deadline_timer_queue
  import dtq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_duration,
  input  wire logic [31:0] in_query_ticket,
  input  wire logic [31:0] in_tick_time,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_ticket_out,
  output logic [31:0]      out_remaining,
  output logic             out_queue_full,
  output logic             out_last
);

  mem_wr_t  wr;
  ptr_t     rd_addr;
  entry_t   rd_data;
  logic     out_free;
  out_req_t req;
  status_t  status;

  dtq_mem u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dtq_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_duration     (in_duration),
    .in_query_ticket (in_query_ticket),
    .in_tick_time    (in_tick_time),
    .wr              (wr),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data),
    .out_free        (out_free),
    .req             (req),
    .status          (status)
  );

  dtq_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .req            (req),
    .out_free       (out_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_ticket_out (out_ticket_out),
    .out_remaining  (out_remaining),
    .out_queue_full (out_queue_full),
    .out_last       (out_last)
  );

  `DTQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, status.count <= CNT_FULL, "entry count over depth")
  `DTQ_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall, "not busy after request")
  `DTQ_ASSERT_NOW(a_idle_last, clk, rst_n, status.state == ST_IDLE && out_valid, out_last, "idle with open result")

endmodule
`default_nettype wire

>>> src/dtq_mem.sv
// Entry memory: one write port, one read port with registered read data
`default_nettype none
module dtq_mem
  import dtq_pkg::*;
(
  input  wire logic    clk,
  input  wire mem_wr_t wr,
  input  wire ptr_t    rd_addr,
  output entry_t       rd_data
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> src/dtq_out.sv
// Result output register
`default_nettype none
module dtq_out
  import dtq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire out_req_t req,
  output logic          out_free,
  output logic          out_valid,
  input  wire logic     out_stall,
  output logic [1:0]    out_kind,
  output logic [31:0]   out_ticket_out,
  output logic [31:0]   out_remaining,
  output logic          out_queue_full,
  output logic          out_last
);

  logic out_valid_r;
  res_t res_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req.vld && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.vld && out_free) begin
      res_r <= req.res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = res_r.kind;
  assign out_ticket_out = res_r.ticket_out;
  assign out_remaining  = res_r.remaining;
  assign out_queue_full = res_r.queue_full;
  assign out_last       = res_r.last;

endmodule
`default_nettype wire

>>> src/dtq_ctrl.sv
// Queue controller: sequencer that reads, shifts and writes back entries
`default_nettype none
module dtq_ctrl
  import dtq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [31:0] in_duration,
  input  wire logic [31:0] in_query_ticket,
  input  wire logic [31:0] in_tick_time,
  output mem_wr_t          wr,
  output ptr_t             rd_addr,
  input  wire entry_t      rd_data,
  input  wire logic        out_free,
  output out_req_t         req,
  output status_t          status
);

  state_t      state_r, state_nxt;
  ptr_t        head_r, head_nxt;
  cnt_t        count_r, count_nxt;
  cnt_t        idx_r, idx_nxt;
  logic [31:0] tc_r, tc_nxt;
  logic [31:0] time_r, time_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [31:0] qtk_r, qtk_nxt;
  res_t        resp_r, resp_nxt;

  logic [32:0] dl_sum;
  entry_t      new_entry;

  assign in_stall  = (state_r != ST_IDLE);
  assign dl_sum    = {1'b0, time_r} + {1'b0, in_duration};
  assign new_entry = '{deadline: dl_r, ticket: resp_r.ticket_out};
  assign status    = '{state: state_r, count: count_r};

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    tc_nxt    = tc_r;
    time_nxt  = time_r;
    dl_nxt    = dl_r;
    qtk_nxt   = qtk_r;
    resp_nxt  = resp_r;
    wr        = '0;
    rd_addr   = head_r;
    req       = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_SCHED: begin
              if (count_r == CNT_FULL) begin
                resp_nxt  = '{kind: KIND_ACK, ticket_out: '0, remaining: '0,
                              queue_full: 1'b1, last: 1'b1};
                state_nxt = ST_RESP;
              end else begin
                dl_nxt    = dl_sum[32] ? '1 : dl_sum[31:0];
                tc_nxt    = tc_r + 32'd1;
                resp_nxt  = '{kind: KIND_ACK, ticket_out: tc_r + 32'd1, remaining: '0,
                              queue_full: 1'b0, last: 1'b1};
                idx_nxt   = count_r;
                if (count_r == '0) begin
                  state_nxt = ST_PUT;
                end else begin
                  rd_addr   = slot(head_r, count_r - cnt_t'(1));
                  state_nxt = ST_INS;
                end
              end
            end
            MODE_QUERY: begin
              qtk_nxt   = in_query_ticket;
              idx_nxt   = '0;
              resp_nxt  = '{kind: KIND_REMAIN, ticket_out: '0, remaining: '0,
                            queue_full: 1'b0, last: 1'b1};
              state_nxt = (count_r == '0) ? ST_RESP : ST_QRY;
            end
            MODE_CLEAR: begin
              count_nxt = '0;
              tc_nxt    = '0;
              resp_nxt  = '{kind: KIND_DONE, ticket_out: '0, remaining: '0,
                            queue_full: 1'b0, last: 1'b1};
              state_nxt = ST_RESP;
            end
            MODE_TICK: begin
              time_nxt  = in_tick_time;
              resp_nxt  = '{kind: KIND_DONE, ticket_out: '0, remaining: '0,
                            queue_full: 1'b0, last: 1'b1};
              state_nxt = ST_TICK;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_INS: begin
        // new entry goes ahead of equal deadlines: shift while deadline >= new
        if (rd_data.deadline >= dl_r) begin
          wr      = '{en: 1'b1, addr: slot(head_r, idx_r), data: rd_data};
          idx_nxt = idx_r - cnt_t'(1);
          if (idx_r == cnt_t'(1)) begin
            state_nxt = ST_PUT;
          end else begin
            rd_addr = slot(head_r, idx_r - cnt_t'(2));
          end
        end else begin
          wr        = '{en: 1'b1, addr: slot(head_r, idx_r), data: new_entry};
          count_nxt = count_r + cnt_t'(1);
          state_nxt = ST_RESP;
        end
      end
      ST_PUT: begin
        wr        = '{en: 1'b1, addr: slot(head_r, idx_r), data: new_entry};
        count_nxt = count_r + cnt_t'(1);
        state_nxt = ST_RESP;
      end
      ST_QRY: begin
        if (rd_data.ticket == qtk_r) begin
          resp_nxt.remaining = (rd_data.deadline > time_r) ? (rd_data.deadline - time_r) : '0;
          state_nxt = ST_RESP;
        end else if (idx_r + cnt_t'(1) == count_r) begin
          state_nxt = ST_RESP;
        end else begin
          idx_nxt = idx_r + cnt_t'(1);
          rd_addr = slot(head_r, idx_r + cnt_t'(1));
        end
      end
      ST_TICK: begin
        if (count_r != '0 && time_r > rd_data.deadline) begin
          if (out_free) begin
            req       = '{vld: 1'b1,
                          res: '{kind: KIND_FIRED, ticket_out: rd_data.ticket,
                                 remaining: '0, queue_full: 1'b0, last: 1'b0}};
            head_nxt  = slot(head_r, cnt_t'(1));
            count_nxt = count_r - cnt_t'(1);
            rd_addr   = slot(head_r, cnt_t'(1));
          end
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          req       = '{vld: 1'b1, res: resp_r};
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      idx_r   <= '0;
      tc_r    <= '0;
      time_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      tc_r    <= tc_nxt;
      time_r  <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dl_r   <= dl_nxt;
    qtk_r  <= qtk_nxt;
    resp_r <= resp_nxt;
  end

endmodule
`default_nettype wire
